/* rtl/count_nonprime_above_threshold_unit_defines.svh */
// Assertion macros shared by the count_nonprime_above_threshold_unit RTL.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef COUNT_NONPRIME_ABOVE_THRESHOLD_UNIT_DEFINES_SVH
`define COUNT_NONPRIME_ABOVE_THRESHOLD_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define CNPAT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never be true outside reset.
`define CNPAT_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

/* rtl/cnpat_pkg.sv */
// Package for the non-prime counter: classification codes, queue tag type
// and the fixed constants of the 6k+-1 trial division. No dependencies.
`default_nettype none

package cnpat_pkg;

   // Width of the threshold register and of the reported running count.
   localparam int THR_BITS       = 32;
   localparam int RSP_COUNT_BITS = 16;

   // Depth of the queue between the classifier and the trial engine.
   localparam int QUEUE_DEPTH = 2;

   // Trial division constants: divisor 3 first, then d and d+2, d = 5, 11, 17...
   localparam int SMALL_DIVISOR = 3;
   localparam int FIRST_TRIAL   = 5;
   localparam int TRIAL_STEP    = 6;
   localparam int PAIR_OFFSET   = 2;

   // Verdict of the classifier for one value.
   typedef enum logic [1:0] {
      CLS_PRIME     = 2'd0,
      CLS_COMPOSITE = 2'd1,
      CLS_TRIAL     = 2'd2
   } class_type;

   // Control part of one queue entry; the magnitude travels beside it.
   typedef struct packed {
      class_type cls;
      logic      above;
      logic      last;
   } tag_type;

endpackage

`default_nettype wire

/* rtl/cnpat_req_if.sv */
// Request channel of the non-prime counter: valid/ready plus one signed value
// and its last-of-list mark. No dependencies.
`default_nettype none

interface cnpat_req_if #(
   parameter int VALUE_BITS = 32
) ();
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;
   logic                         last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

/* rtl/cnpat_rsp_if.sv */
// Response channel of the non-prime counter: valid/ready plus the verdict,
// the counted flag, the running count and the echoed last mark. Uses cnpat_pkg.
`default_nettype none

interface cnpat_rsp_if import cnpat_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      is_prime;
   logic                      counted;
   logic [RSP_COUNT_BITS-1:0] running_count;
   logic                      last_out;

   modport source (output valid, output is_prime, output counted, output running_count,
                   output last_out, input ready);
   modport sink   (input valid, input is_prime, input counted, input running_count,
                   input last_out, output ready);
endinterface

`default_nettype wire

/* rtl/count_nonprime_above_threshold_unit.sv */
// Top level of the non-prime counter: classifier, queue, trial engine and
// remainder pipeline. Uses cnpat_pkg, cnpat_req_if, cnpat_rsp_if and submodules.
`default_nettype none

// Counts values that are not prime and lie above a signed threshold, over lists
// closed by a last mark; one response per request, in order, with the running
// count saturating at 2^COUNT_BITS-1 and cleared after the last item. The front
// classifies each value on acceptance and a two-entry queue lets it take new
// requests while the back works. Negative values, values up to 3 and even
// values skip the trials and go straight to the response. Odd values from 5
// up are tried against 3 and the pairs 6k-1, 6k+1 on a remainder pipeline of
// VALUE_BITS-1 stages that takes one divisor per cycle, and issue stops early
// once a divisor is found. The threshold must only be written while idle.
module count_nonprime_above_threshold_unit import cnpat_pkg::*; #(
   parameter int VALUE_BITS = 32,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_en,
   input  wire logic [THR_BITS-1:0] csr_write_data,
   cnpat_req_if.sink                req,
   cnpat_rsp_if.source              rsp
);

   localparam int MW = VALUE_BITS - 1;
   localparam int DW = MW + $bits(tag_type);

   logic          queue_push;
   logic          queue_full;
   logic [DW-1:0] push_data;
   logic          queue_pop;
   logic          queue_empty;
   logic [DW-1:0] pop_data;
   logic          issue_valid;
   logic [MW-1:0] issue_div;
   logic [MW-1:0] mag;
   logic          ret_valid;
   logic          ret_zero;

   // Accept and classify.
   cnpat_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req            (req),
      .queue_full     (queue_full),
      .queue_push     (queue_push),
      .queue_data     (push_data)
   );

   // Decouple front and back.
   cnpat_queue #(
      .DATA_BITS (DW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   // Trial sequencing, counting and response.
   cnpat_back #(
      .VALUE_BITS (VALUE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_data  (pop_data),
      .queue_pop   (queue_pop),
      .issue_valid (issue_valid),
      .issue_div   (issue_div),
      .mag         (mag),
      .ret_valid   (ret_valid),
      .ret_zero    (ret_zero),
      .rsp         (rsp)
   );

   // One remainder per cycle against the current magnitude.
   cnpat_rem_pipe #(
      .MAG_BITS (MW)
   ) u_rem_pipe (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (issue_valid),
      .issue_div   (issue_div),
      .mag         (mag),
      .ret_valid   (ret_valid),
      .ret_zero    (ret_zero)
   );

endmodule

`default_nettype wire

/* rtl/cnpat_front.sv */
// Front end: holds the threshold register, accepts request transfers and
// classifies each value before it enters the queue. Uses cnpat_pkg, cnpat_req_if.
`default_nettype none

module cnpat_front import cnpat_pkg::*; #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire logic [THR_BITS-1:0]   csr_write_data,
   cnpat_req_if.sink                  req,
   input  wire logic                  queue_full,
   output logic                       queue_push,
   output logic [VALUE_BITS-2+$bits(tag_type):0] queue_data
);

   localparam int MW = VALUE_BITS - 1;
   localparam int CW = (VALUE_BITS > THR_BITS) ? VALUE_BITS : THR_BITS;

   logic signed [THR_BITS-1:0] threshold_ff;
   logic signed [THR_BITS-1:0] threshold_in;
   logic signed [CW-1:0]       value_ext;
   logic signed [CW-1:0]       thr_ext;
   logic [MW-1:0]              mag;
   logic                       negative;
   tag_type                    tag;

   // Threshold register; the user must write it only while the block is idle, which the block itself does not enforce.
   assign threshold_in = csr_write_en ? signed'(csr_write_data) : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // Take a request whenever the queue has room.
   assign req.ready  = !queue_full;
   assign queue_push = req.valid && !queue_full;

   // Full signed comparison against the threshold.
   assign value_ext = CW'(req.value);
   assign thr_ext   = CW'(threshold_ff);

   assign negative = req.value[VALUE_BITS-1];
   assign mag      = req.value[MW-1:0];

   // Settle the easy cases here; only odd values of five and up need trials.
   always_comb begin
      tag.above = value_ext > thr_ext;
      tag.last  = req.last;
      priority if (negative || mag <= MW'(1)) begin
         tag.cls = CLS_COMPOSITE;
      end else if (mag <= MW'(SMALL_DIVISOR)) begin
         tag.cls = CLS_PRIME;
      end else if (!mag[0]) begin
         tag.cls = CLS_COMPOSITE;
      end else begin
         tag.cls = CLS_TRIAL;
      end
   end

   assign queue_data = {tag, mag};

endmodule

`default_nettype wire

/* rtl/cnpat_queue.sv */
// Short first-in first-out queue between the classifier and the trial engine.
// Uses cnpat_pkg for its depth.
`default_nettype none

module cnpat_queue import cnpat_pkg::*; #(
   parameter int DATA_BITS = 34
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic [DATA_BITS-1:0] push_data,
   output logic                      full,
   input  wire logic                 pop,
   output logic [DATA_BITS-1:0]      pop_data,
   output logic                      empty
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [DATA_BITS-1:0] entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]        wr_ptr_ff;
   logic [PW-1:0]        wr_ptr_in;
   logic [PW-1:0]        rd_ptr_ff;
   logic [PW-1:0]        rd_ptr_in;
   logic [PW:0]          fill_ff;
   logic [PW:0]          fill_in;

   assign full     = fill_ff == (PW+1)'(QUEUE_DEPTH);
   assign empty    = fill_ff == '0;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointers wrap naturally because the depth is a power of two.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      fill_in   = fill_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/cnpat_rem_pipe.sv */
// Pipelined remainder unit: one divisor enters per cycle, and each stage does
// one restoring step against the shared dividend. Depends on nothing else.
`default_nettype none

module cnpat_rem_pipe #(
   parameter int MAG_BITS = 31
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                issue_valid,
   input  wire logic [MAG_BITS-1:0] issue_div,
   input  wire logic [MAG_BITS-1:0] mag,
   output logic                     ret_valid,
   output logic                     ret_zero
);

   logic [MAG_BITS-1:0] rem_ff [MAG_BITS];
   logic [MAG_BITS-1:0] rem_in [MAG_BITS];
   logic [MAG_BITS-1:0] div_ff [MAG_BITS];
   logic [MAG_BITS-1:0] vld_ff;

   // Stage k brings down dividend bit MAG_BITS-1-k and subtracts if it can.
   for (genvar k = 0; k < MAG_BITS; k++) begin : g_stage
      logic [MAG_BITS-1:0] rem_prev;
      logic [MAG_BITS-1:0] div_prev;
      logic                vld_prev;
      logic [MAG_BITS:0]   trial;
      logic [MAG_BITS:0]   diff;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign div_prev = issue_div;
         assign vld_prev = issue_valid;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign div_prev = div_ff[k-1];
         assign vld_prev = vld_ff[k-1];
      end

      assign trial = {rem_prev, mag[MAG_BITS-1-k]};
      assign diff  = trial - {1'b0, div_prev};

      always_comb begin
         if (trial >= {1'b0, div_prev}) begin
            rem_in[k] = diff[MAG_BITS-1:0];
         end else begin
            rem_in[k] = trial[MAG_BITS-1:0];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in[k];
         div_ff[k] <= div_prev;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
      end
   end

   assign ret_valid = vld_ff[MAG_BITS-1];
   assign ret_zero  = rem_ff[MAG_BITS-1] == '0;

endmodule

`default_nettype wire

/* rtl/cnpat_back.sv */
// Back end: pops classified values, drives the remainder pipeline with the
// 6k+-1 divisors, keeps the running count and holds the response register.
// Uses cnpat_pkg, cnpat_rsp_if and the assertion macros.
`default_nettype none
`include "count_nonprime_above_threshold_unit_defines.svh"

module cnpat_back import cnpat_pkg::*; #(
   parameter int VALUE_BITS = 32,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  queue_empty,
   input  wire logic [VALUE_BITS-2+$bits(tag_type):0] queue_data,
   output logic                       queue_pop,
   output logic                       issue_valid,
   output logic [VALUE_BITS-2:0]      issue_div,
   output logic [VALUE_BITS-2:0]      mag,
   input  wire logic                  ret_valid,
   input  wire logic                  ret_zero,
   cnpat_rsp_if.source                rsp
);

   localparam int MW  = VALUE_BITS - 1;
   localparam int SQW = MW + 2;
   localparam int IW  = $clog2(MW + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef enum logic [2:0] {
      PH_THREE = 3'b001,
      PH_LOW   = 3'b010,
      PH_HIGH  = 3'b100
   } phase_type;

   state_type                 state_ff, state_in;
   phase_type                 phase_ff, phase_in;
   tag_type                   tag_ff, tag_in;
   tag_type                   queue_tag;
   logic [MW-1:0]             mag_ff, mag_in;
   logic [MW-1:0]             d_ff, d_in;
   logic [SQW-1:0]            sq_ff, sq_in;
   logic                      found_ff, found_in;
   logic                      issue_done_ff, issue_done_in;
   logic [IW-1:0]             inflight_ff, inflight_in;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic [COUNT_BITS-1:0]     count_next;
   logic [COUNT_BITS+RSP_COUNT_BITS-1:0] count_wide;
   logic                      prime;
   logic                      hit;
   logic                      out_free;
   logic                      out_valid_ff, out_valid_in;
   logic                      out_prime_ff, out_prime_in;
   logic                      out_counted_ff, out_counted_in;
   logic [RSP_COUNT_BITS-1:0] out_count_ff, out_count_in;
   logic                      out_last_ff, out_last_in;

   assign queue_tag = tag_type'(queue_data[MW+$bits(tag_type)-1:MW]);
   assign mag       = mag_ff;

   // Verdict and count update for the item in hand.
   assign prime      = (tag_ff.cls == CLS_PRIME) || (tag_ff.cls == CLS_TRIAL && !found_ff);
   assign hit        = !prime && tag_ff.above;
   assign count_next = (hit && count_ff != '1) ? count_ff + COUNT_BITS'(1) : count_ff;
   assign count_wide = {{RSP_COUNT_BITS{1'b0}}, count_next};

   assign out_free = !out_valid_ff || rsp.ready;

   // Sequencer: pop, issue divisors for trial items, drain the pipeline, then post the response.
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      tag_in         = tag_ff;
      mag_in         = mag_ff;
      d_in           = d_ff;
      sq_in          = sq_ff;
      found_in       = found_ff | (ret_valid & ret_zero);
      issue_done_in  = issue_done_ff;
      count_in       = count_ff;
      queue_pop      = 1'b0;
      issue_valid    = 1'b0;
      issue_div      = d_ff;
      out_valid_in   = out_valid_ff && !rsp.ready;
      out_prime_in   = out_prime_ff;
      out_counted_in = out_counted_ff;
      out_count_in   = out_count_ff;
      out_last_in    = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               queue_pop     = 1'b1;
               tag_in        = queue_tag;
               mag_in        = queue_data[MW-1:0];
               d_in          = MW'(FIRST_TRIAL);
               sq_in         = SQW'(FIRST_TRIAL * FIRST_TRIAL);
               phase_in      = PH_THREE;
               found_in      = 1'b0;
               issue_done_in = 1'b0;
               state_in      = (queue_tag.cls == CLS_TRIAL) ? ST_RUN : ST_DONE;
            end
         end
         ST_RUN: begin
            if (!found_ff && !issue_done_ff) begin
               unique case (phase_ff)
                  PH_THREE: begin
                     issue_valid = 1'b1;
                     issue_div   = MW'(SMALL_DIVISOR);
                     phase_in    = PH_LOW;
                  end
                  PH_LOW: begin
                     if (sq_ff > SQW'(mag_ff)) begin
                        issue_done_in = 1'b1;
                     end else begin
                        issue_valid = 1'b1;
                        phase_in    = PH_HIGH;
                     end
                  end
                  PH_HIGH: begin
                     issue_valid = 1'b1;
                     issue_div   = d_ff + MW'(PAIR_OFFSET);
                     d_in        = d_ff + MW'(TRIAL_STEP);
                     sq_in       = sq_ff + SQW'(d_ff) * SQW'(2 * TRIAL_STEP)
                                   + SQW'(TRIAL_STEP * TRIAL_STEP);
                     phase_in    = PH_LOW;
                  end
                  default: begin
                     phase_in = PH_LOW;
                  end
               endcase
            end
            if ((found_ff || issue_done_ff) && inflight_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_prime_in   = prime;
               out_counted_in = hit;
               out_count_in   = count_wide[RSP_COUNT_BITS-1:0];
               out_last_in    = tag_ff.last;
               count_in       = tag_ff.last ? '0 : count_next;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Divisors in flight in the remainder pipeline.
   assign inflight_in = inflight_ff + IW'(issue_valid) - IW'(ret_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_THREE;
         found_ff      <= 1'b0;
         issue_done_ff <= 1'b0;
         inflight_ff   <= '0;
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         found_ff      <= found_in;
         issue_done_ff <= issue_done_in;
         inflight_ff   <= inflight_in;
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Item and response payload registers.
   always_ff @(posedge clock) begin
      tag_ff         <= tag_in;
      mag_ff         <= mag_in;
      d_ff           <= d_in;
      sq_ff          <= sq_in;
      out_prime_ff   <= out_prime_in;
      out_counted_ff <= out_counted_in;
      out_count_ff   <= out_count_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.is_prime      = out_prime_ff;
   assign rsp.counted       = out_counted_ff;
   assign rsp.running_count = out_count_ff;
   assign rsp.last_out      = out_last_ff;

   // The dividend may only change with the pipeline empty.
   `CNPAT_ASSERT(a_pop_only_idle, queue_pop |-> state_ff == ST_IDLE && inflight_ff == '0, "queue popped while busy")
   `CNPAT_ASSERT(a_issue_only_run, issue_valid |-> state_ff == ST_RUN, "divisor issued outside run")
   `CNPAT_ASSERT_NEVER(a_retire_underflow, ret_valid && inflight_ff == '0, "remainder returned with none in flight")
   `CNPAT_ASSERT(a_done_drained, state_ff == ST_DONE |-> inflight_ff == '0, "verdict posted before pipeline drained")

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for count_nonprime_above_threshold_unit.
// Needs cnpat_pkg, cnpat_req_if, cnpat_rsp_if and the unit itself. It predicts each
// verdict and running count by trial division and checks every response in order.

module tb import cnpat_pkg::*;;

   localparam int VALUE_BITS    = 32;
   localparam int COUNT_BITS    = 16;
   localparam int COUNT_MAX     = (1 << COUNT_BITS) - 1;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 10_000_000;
   localparam int MAX_REPORTS   = 20;
   localparam int SEGMENT_ITEMS = 6;

   localparam logic signed [VALUE_BITS-1:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [VALUE_BITS-1:0] MOST_POS = 32'sh7FFF_FFFF;

   // One expected response.
   typedef struct packed {
      logic                      is_prime;
      logic                      counted;
      logic [RSP_COUNT_BITS-1:0] running_count;
      logic                      last_out;
   } verdict_type;

   logic                clock;
   logic                reset;
   logic                csr_write_en;
   logic [THR_BITS-1:0] csr_write_data;

   cnpat_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
   cnpat_rsp_if                            rsp_ch ();

   count_nonprime_above_threshold_unit #(
      .VALUE_BITS(VALUE_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data),
      .req           (req_ch.sink),
      .rsp           (rsp_ch.source)
   );

   // Shadow copy of the unit's threshold and list count.
   logic signed [THR_BITS-1:0] threshold_model;
   logic [COUNT_BITS-1:0]      list_tally;
   verdict_type                pending_verdicts[$];

   int          send_idle_pct;
   int          recv_idle_pct;
   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned items_sent;
   int unsigned lists_sent;
   int unsigned results_checked;
   int unsigned threshold_writes;

   // Clock generation.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycle_count, pending_verdicts.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side back-pressure.
   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Primality of a signed value by trial division with 6k-1 and 6k+1 divisors.
   function automatic logic trial_is_prime(input logic signed [VALUE_BITS-1:0] v);
      longint unsigned m;
      longint unsigned d;
      if (v <= 1)
         return 1'b0;
      m = longint'(v);
      if (m <= SMALL_DIVISOR)
         return 1'b1;
      if (m % PAIR_OFFSET == 0 || m % SMALL_DIVISOR == 0)
         return 1'b0;
      for (d = FIRST_TRIAL; d * d <= m; d += TRIAL_STEP) begin
         if (m % d == 0 || m % (d + PAIR_OFFSET) == 0)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // Work out the response to one accepted request and advance the list count.
   task automatic predict_verdict(input logic signed [VALUE_BITS-1:0] v, input logic last);
      verdict_type want;
      want.is_prime = trial_is_prime(v);
      want.counted  = !want.is_prime && (v > threshold_model);
      if (want.counted && list_tally != COUNT_BITS'(COUNT_MAX))
         list_tally = list_tally + 1'b1;
      want.running_count = RSP_COUNT_BITS'(list_tally);
      want.last_out      = last;
      pending_verdicts.push_back(want);
      items_sent++;
      if (last) begin
         list_tally = '0;
         lists_sent++;
      end
   endtask

   task automatic report_mismatch(input string what, input longint want, input longint got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
   endtask

   // Check each response transfer against the oldest expectation.
   always @(posedge clock) begin : check_responses
      verdict_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_verdicts.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: response with none expected, expected none, actual %0b/%0b/%0d/%0b",
                        $time, rsp_ch.is_prime, rsp_ch.counted, rsp_ch.running_count,
                        rsp_ch.last_out);
         end else begin
            want = pending_verdicts.pop_front();
            results_checked++;
            if (rsp_ch.is_prime !== want.is_prime)
               report_mismatch("is_prime", want.is_prime, rsp_ch.is_prime);
            if (rsp_ch.counted !== want.counted)
               report_mismatch("counted", want.counted, rsp_ch.counted);
            if (rsp_ch.running_count !== want.running_count)
               report_mismatch("running_count", want.running_count, rsp_ch.running_count);
            if (rsp_ch.last_out !== want.last_out)
               report_mismatch("last_out", want.last_out, rsp_ch.last_out);
         end
      end
   end

   // Send one request; valid stays high into the next call unless a gap is drawn.
   task automatic send_item(input logic signed [VALUE_BITS-1:0] v, input logic last);
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      req_ch.last  <= last;
      do @(posedge clock); while (!req_ch.ready);
      predict_verdict(v, last);
   endtask

   // Stop sending and wait until every expected response has been checked.
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Threshold write; only called once the unit is idle.
   task automatic write_threshold(input logic signed [THR_BITS-1:0] t);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= t;
      @(posedge clock);
      csr_write_en    <= 1'b0;
      threshold_model  = t;
      threshold_writes++;
   endtask

   // Random value: mostly small magnitudes, a few across the full range.
   function automatic logic signed [VALUE_BITS-1:0] random_value();
      int unsigned pick;
      logic signed [VALUE_BITS-1:0] v;
      pick = $urandom_range(0, 99);
      if (pick < 35)
         v = int'($urandom_range(0, 400)) - 100;
      else if (pick < 60)
         v = int'($urandom_range(0, 65535));
      else if (pick < 75)
         v = int'($urandom_range(0, 1 << 20)) | 1;
      else if (pick < 85)
         v = {1'b1, 31'($urandom)};
      else
         v = $urandom;
      return v;
   endfunction

   // Boundary values: small primes, squares and pair products, largest magnitudes.
   task automatic test_directed_values();
      logic signed [VALUE_BITS-1:0] vals[$];
      bit                           marks[$];
      vals  = '{MOST_NEG, -1, 0, 1, 2, 3, 4, 25, 35, 49, 121, 143, 169,
                MOST_POS, 32'sd2147117569, 32'sd2147483646};
      marks = '{0, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0, 0, 1};
      foreach (vals[i])
         send_item(vals[i], marks[i]);
      drain_responses();
   endtask

   // Threshold at both ends of its range and at a value that appears in the list.
   task automatic test_threshold_extremes();
      logic signed [THR_BITS-1:0]   thresholds[$];
      logic signed [VALUE_BITS-1:0] vals[$];
      thresholds = '{MOST_NEG, MOST_POS, 8};
      vals       = '{MOST_NEG, -32'sd2147483647, 8, 32'sd2147483646};
      foreach (thresholds[t]) begin
         write_threshold(thresholds[t]);
         foreach (vals[i])
            send_item(vals[i], i == vals.size() - 1);
         drain_responses();
      end
   endtask

   // Random lists in three segments, each under a fresh threshold.
   task automatic test_random_lists(input int sender_pct, input int receiver_pct);
      int                         sent;
      int                         len;
      logic signed [THR_BITS-1:0] t;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      for (int seg = 0; seg < 3; seg++) begin
         if ($urandom_range(0, 2) != 0)
            t = int'($urandom_range(0, 600)) - 300;
         else
            t = $urandom;
         write_threshold(t);
         sent = 0;
         while (sent < SEGMENT_ITEMS) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
               send_item(random_value(), k == len - 1);
            sent += len;
         end
         drain_responses();
      end
   endtask

   initial begin
      reset            <= 1'b1;
      csr_write_en     <= 1'b0;
      csr_write_data   <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.value     <= '0;
      req_ch.last      <= 1'b0;
      threshold_model   = '0;
      list_tally        = '0;
      cycle_count       = 0;
      error_count       = 0;
      items_sent        = 0;
      lists_sent        = 0;
      results_checked   = 0;
      threshold_writes  = 0;
      send_idle_pct     = 36;
      recv_idle_pct     = 53;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_values();
      test_threshold_extremes();
      test_random_lists(36, 53);
      test_random_lists(53, 36);
      test_random_lists(0, 0);

      $display("Run covered %0d requests in %0d lists under %0d threshold settings,",
               items_sent, lists_sent, threshold_writes + 1);
      $display("with both stall patterns and with none; %0d responses checked, %0d errors.",
               results_checked, error_count);
      if (error_count == 0 && pending_verdicts.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
